/* rtl/cmu_pkg.sv */
// Shared types, register codes and step counts for the math unit.
package cmu_pkg;

    // Access direction
    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    // Register offsets within the window
    localparam logic [4:0] REG_MCAND   = 5'h02;
    localparam logic [4:0] REG_MPLR    = 5'h03;
    localparam logic [4:0] REG_DVD_LO  = 5'h04;
    localparam logic [4:0] REG_DVD_HI  = 5'h05;
    localparam logic [4:0] REG_DIVISOR = 5'h06;
    localparam logic [4:0] REG_QUOT_LO = 5'h14;
    localparam logic [4:0] REG_QUOT_HI = 5'h15;
    localparam logic [4:0] REG_RES_LO  = 5'h16;
    localparam logic [4:0] REG_RES_HI  = 5'h17;

    // Quotient reported for a zero divisor
    localparam logic [15:0] QUOT_DIV_ZERO = 16'hFFFF;
    // Multiplicand after reset
    localparam logic [7:0]  MCAND_RESET   = 8'hFF;

    // One bit per cycle: 8 steps for the multiply, 16 for the divide
    localparam int MUL_STEPS = 8;
    localparam int DIV_STEPS = 16;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS);
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam logic [MUL_CNT_W-1:0] MUL_LAST = MUL_CNT_W'(MUL_STEPS - 1);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    // Control sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV
    } t_state;

endpackage

/* rtl/cmu_mul.sv */
// Serial 8x8 unsigned multiplier, one multiplier bit per cycle (shift-add).
module cmu_mul
    import cmu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [7:0]  i_mcand,
    input  logic [7:0]  i_mplr,
    output logic        o_done,
    output logic [15:0] o_product
);

    logic                 r_busy;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic [7:0]           r_mcand;
    logic [15:0]          r_acc;   // upper: partial sum, lower: multiplier bits left
    logic [15:0]          n_acc;
    logic [8:0]           w_sum;

    // Add multiplicand into upper half when the current bit is set, then shift right
    always_comb begin
        w_sum = {1'b0, r_acc[15:8]} + {1'b0, (r_acc[0] ? r_mcand : 8'h00)};
        n_acc = {w_sum, r_acc[7:1]};
    end

    assign o_done    = r_busy && (r_cnt == MUL_LAST);
    assign o_product = n_acc;

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == MUL_LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand <= i_mcand;
            r_acc   <= {8'h00, i_mplr};
        end else if (r_busy) begin
            r_acc <= n_acc;
        end
    end

endmodule

/* rtl/cmu_div.sv */
// Serial 16/8 unsigned restoring divider, one quotient bit per cycle.
module cmu_div
    import cmu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_dividend,
    input  logic [7:0]  i_divisor,
    output logic        o_done,
    output logic [15:0] o_quotient,
    output logic [15:0] o_remainder
);

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [7:0]           r_dvsr;
    logic [7:0]           r_rem;
    logic [15:0]          r_quo;   // dividend bits shift out the top, quotient in the bottom
    logic [8:0]           w_trial;
    logic [8:0]           w_diff;
    logic                 w_ge;
    logic [7:0]           n_rem;
    logic [15:0]          n_quo;

    // Bring down the next dividend bit and try a subtract
    // (partial remainder stays below the divisor, so a borrow means trial < divisor)
    always_comb begin
        w_trial = {r_rem, r_quo[15]};
        w_diff  = w_trial - {1'b0, r_dvsr};
        w_ge    = !w_diff[8];
        n_rem   = w_ge ? w_diff[7:0] : w_trial[7:0];
        n_quo   = {r_quo[14:0], w_ge};
    end

    assign o_done      = r_busy && (r_cnt == DIV_LAST);
    assign o_quotient  = n_quo;
    assign o_remainder = {8'h00, n_rem};

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvsr <= i_divisor;
            r_rem  <= 8'h00;
            r_quo  <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

endmodule

/* rtl/cpu_math_unit.sv */
// Math unit top level: register window, access sequencer and response register.
//
// Each bus access is one input word and yields exactly one response word
// (read_data, hit). Reads and plain writes are answered in the cycle after
// acceptance. A write to the multiplier register (3) runs the serial
// multiplier, and a write with a nonzero divisor to register 6 runs the
// serial divider; both are answered at once, but the next access is held
// off by o_in_stall until the result registers are updated, so a following
// read always sees the finished result. A zero divisor does not start the
// divider; the write sets the results. The serial units are one-bit-per-cycle
// shift-add and shift-subtract loops. The response register lets a new access
// be taken while it is drained.
module cpu_math_unit
    import cmu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_action,
    input  logic [4:0] i_reg_index,
    input  logic [7:0] i_write_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_read_data,
    output logic       o_hit
);

    t_state      r_state, n_state;
    logic [7:0]  r_mcand;
    logic [15:0] r_dividend;
    logic [15:0] r_quot;
    logic [15:0] r_res;
    logic        r_out_valid;
    logic [7:0]  r_read_data;
    logic        r_hit;

    logic        w_accept;
    logic        w_mul_start, w_div_start;
    logic        w_is_mplr, w_is_div, w_div_zero;
    logic [7:0]  w_rd;
    logic        w_hit;

    logic        w_mul_done;
    logic [15:0] w_product;
    logic        w_div_done;
    logic [15:0] w_div_quot, w_div_rem;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_is_mplr  = (i_action == ACT_WRITE) && (i_reg_index == REG_MPLR);
    assign w_is_div   = (i_action == ACT_WRITE) && (i_reg_index == REG_DIVISOR);
    assign w_div_zero = (i_write_data == 8'h00);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && w_is_mplr) begin
                    n_state = S_MUL;
                end else if (w_accept && w_is_div && !w_div_zero) begin
                    n_state = S_DIV;
                end
            end
            S_MUL: begin
                if (w_mul_done) begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_in_stall  = 1'b1;
        w_mul_start = 1'b0;
        w_div_start = 1'b0;
        unique case (r_state) inside
            S_IDLE: begin
                o_in_stall  = r_out_valid && i_out_stall;
                w_mul_start = w_accept && w_is_mplr;
                w_div_start = w_accept && w_is_div && !w_div_zero;
            end
            S_MUL, S_DIV: begin
                o_in_stall = 1'b1;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

    // Response decode
    always_comb begin
        w_rd  = 8'h00;
        w_hit = 1'b0;
        if (i_action == ACT_WRITE) begin
            unique case (i_reg_index) inside
                REG_MCAND, REG_MPLR, REG_DVD_LO, REG_DVD_HI, REG_DIVISOR: w_hit = 1'b1;
                default: w_hit = 1'b0;
            endcase
        end else begin
            unique case (i_reg_index)
                REG_QUOT_LO: begin w_rd = r_quot[7:0];  w_hit = 1'b1; end
                REG_QUOT_HI: begin w_rd = r_quot[15:8]; w_hit = 1'b1; end
                REG_RES_LO:  begin w_rd = r_res[7:0];   w_hit = 1'b1; end
                REG_RES_HI:  begin w_rd = r_res[15:8];  w_hit = 1'b1; end
                default: begin w_rd = 8'h00; w_hit = 1'b0; end
            endcase
        end
    end

    // State and response word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_mcand     <= MCAND_RESET;
            r_dividend  <= '0;
            r_quot      <= '0;
            r_res       <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            // Register writes
            if (w_accept && (i_action == ACT_WRITE)) begin
                unique case (i_reg_index)
                    REG_MCAND:  r_mcand <= i_write_data;
                    REG_MPLR:   r_quot  <= {8'h00, i_write_data};
                    REG_DVD_LO: r_dividend[7:0]  <= i_write_data;
                    REG_DVD_HI: r_dividend[15:8] <= i_write_data;
                    REG_DIVISOR: begin
                        if (w_div_zero) begin
                            r_quot <= QUOT_DIV_ZERO;
                            r_res  <= r_dividend;
                        end
                    end
                    default: ;
                endcase
            end

            // Serial unit results
            if (w_mul_done) begin
                r_res <= w_product;
            end
            if (w_div_done) begin
                r_quot <= w_div_quot;
                r_res  <= w_div_rem;
            end
        end
    end

    // Response payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_read_data <= w_rd;
            r_hit       <= w_hit;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_read_data;
    assign o_hit       = r_hit;

    cmu_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mul_start),
        .i_mcand   (r_mcand),
        .i_mplr    (i_write_data),
        .o_done    (w_mul_done),
        .o_product (w_product)
    );

    cmu_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (r_dividend),
        .i_divisor   (i_write_data),
        .o_done      (w_div_done),
        .o_quotient  (w_div_quot),
        .o_remainder (w_div_rem)
    );

endmodule
